[src/stbs_pkg.sv]
package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int VAL_W       = 32;
	localparam int CNT_W       = 11;
	localparam int POS_W       = 10;
	localparam int RNG_W       = CNT_W + 1;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

endpackage

[src/stbs_if.sv]
interface stbs_req_if import stbs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic [POS_W-1:0]        entry_index;
	logic signed [VAL_W-1:0] entry_value;
	logic signed [VAL_W-1:0] search_key;

	modport source (output valid, kind, entry_index, entry_value, search_key, input ready);
	modport sink   (input valid, kind, entry_index, entry_value, search_key, output ready);
endinterface

interface stbs_rsp_if import stbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;

	modport source (output valid, found, position, input ready);
	modport sink   (input valid, found, position, output ready);
endinterface

[src/stbs_ram.sv]
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/sorted_table_binary_search.sv]
// Sorted table with binary search.
// Requests arrive on req (valid/ready). A write request stores entry_value
// at entry_index and gives no response. A search
// request looks search_key up over the first entries_in_use entries (held
// in a register written through cfg_we/cfg_wdata, saturated at the table
// depth) and gives one response on rsp: found, and position (0 on a miss).
// On acceptance a search issues its first probe to the table, then one
// probe follows another: 1 to 11 probes for a 1024-entry table. The
// response is registered: it is loaded when the deciding probe is seen and
// the response register is free. Searches are bounded by the single table
// read port and the key compare (equal and less-than), used once per probe.
// req.ready is high only while no search is under way; write requests are
// taken even while a response waits on rsp. If rsp is stalled when a
// search finishes, the search holds its last probe until the response
// register frees up.
// Reset clears the control state and entries_in_use; table contents are
// undefined until written.
module sorted_table_binary_search import stbs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	stbs_req_if.sink         req,
	stbs_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_PROBE = 2'b10
	} state_t;

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        entries_in_use_q;
	logic [CNT_W-1:0]        cnt_sat;
	logic signed [VAL_W-1:0] key_q, rd_data;
	logic signed [RNG_W-1:0] low_q, high_q, low_d, high_d;
	logic signed [RNG_W-1:0] init_high, new_low, new_high, mid_ext;
	logic [ADDR_W-1:0]       mid_q, rd_addr;
	logic                    ram_we, is_hit, is_less, empty, finish, out_free;
	logic                    rsp_valid_q, found_q, rsp_load;
	logic [POS_W-1:0]        position_q;

	function automatic logic [ADDR_W-1:0] mid_of(input logic signed [RNG_W-1:0] lo,
	                                             input logic signed [RNG_W-1:0] hi);
		logic [RNG_W-1:0] sum;
		sum = lo + hi;
		return sum[ADDR_W:1];
	endfunction

	stbs_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req.entry_index[ADDR_W-1:0]),
		.wdata (req.entry_value),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		cnt_sat   = (entries_in_use_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
		                                                     : entries_in_use_q;
		init_high = $signed({1'b0, cnt_sat}) - RNG_W'(1);
		mid_ext   = $signed({{(RNG_W-ADDR_W){1'b0}}, mid_q});
		is_hit    = (rd_data == key_q);
		is_less   = (key_q < rd_data);
		empty     = (high_q < low_q);
		new_low   = is_less ? low_q : mid_ext + RNG_W'(1);
		new_high  = is_less ? mid_ext - RNG_W'(1) : high_q;
		finish    = empty || is_hit || (new_high < new_low);

		state_d  = state_q;
		low_d    = low_q;
		high_d   = high_q;
		rd_addr  = mid_q;
		ram_we   = 1'b0;
		rsp_load = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.kind == KIND_WRITE) begin
						ram_we = (32'(req.entry_index) < TABLE_DEPTH);
					end else begin
						low_d   = '0;
						high_d  = init_high;
						rd_addr = mid_of('0, init_high);
						state_d = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				if (finish) begin
					if (out_free) begin
						rsp_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					low_d   = new_low;
					high_d  = new_high;
					rd_addr = mid_of(new_low, new_high);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			entries_in_use_q <= '0;
			rsp_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				entries_in_use_q <= cfg_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		low_q  <= low_d;
		high_q <= high_d;
		mid_q  <= rd_addr;
		if (state_q == ST_IDLE && req.valid && req.kind == KIND_SEARCH) begin
			key_q <= req.search_key;
		end
		if (rsp_load) begin
			found_q    <= !empty && is_hit;
			position_q <= (!empty && is_hit) ? POS_W'(mid_q) : '0;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.found    = found_q;
	assign rsp.position = position_q;

	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.kind == KIND_SEARCH |=> state_q == ST_PROBE)
		else $error("search request did not start probing");

	a_range_sane: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> low_q <= high_q + RNG_W'(1))
		else $error("search range overran by more than one entry");

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.position == '0)
		else $error("miss response with non-zero position");

endmodule
